>>> hdl/moesif_snoop_coherence_controller_macros.svh
// Assertion macros for the MOESIF snoop coherence controller.
`ifndef MOESIF_SNOOP_COHERENCE_CONTROLLER_MACROS_SVH
`define MOESIF_SNOOP_COHERENCE_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define MSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("moesif controller check failed");

// Delayed implication, sampled on clk_i, off during reset.
`define MSC_ASSERT_LAT2(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##2 (cons)) \
    else $error("moesif controller latency check failed");

`endif

>>> hdl/msc_pkg.sv
// Shared types and constants for the MOESIF snoop coherence controller.
package msc_pkg;

  localparam int unsigned LINES_DEF         = 256;
  localparam int unsigned CACHE_ID_BITS_DEF = 4;
  localparam int unsigned OP_W              = 3;
  localparam int unsigned LINE_IN_W         = 8;
  localparam int unsigned ADDR_W            = 32;

  typedef enum logic [2:0] {
    ST_I  = 3'd0,
    ST_S  = 3'd1,
    ST_E  = 3'd2,
    ST_O  = 3'd3,
    ST_M  = 3'd4,
    ST_F  = 3'd5,
    ST_IM = 3'd6,
    ST_IS = 3'd7
  } line_state_e;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_STORE = 3'd1,
    OP_GETS  = 3'd2,
    OP_GETM  = 3'd3,
    OP_DATA  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    REQ_NONE = 2'd0,
    REQ_GETS = 2'd1,
    REQ_GETM = 2'd2
  } bus_req_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_INVALID = 2'd1,
    ERR_PENDING = 2'd2
  } err_e;

  typedef struct packed {
    bus_req_e    breq;
    logic        to_proc;
    logic        on_bus;
    logic        shared;
    logic        miss;
    logic        silent;
    err_e        err;
    line_state_e ns;
  } action_t;

endpackage

>>> hdl/msc_xact.sv
// Coherence transition logic: line state and event in, actions and next state out.
module msc_xact (
  input  logic [msc_pkg::OP_W-1:0] op_i,
  input  msc_pkg::line_state_e     state_i,
  input  logic                     shared_i,
  output msc_pkg::action_t         action_o
);
  import msc_pkg::*;

  always_comb begin
    action_o         = '0;
    action_o.breq    = REQ_NONE;
    action_o.err     = ERR_NONE;
    action_o.ns      = state_i;
    case (op_i)
      OP_LOAD, OP_STORE: begin
        case (state_i)
          ST_I: begin
            action_o.ns   = (op_i == OP_STORE) ? ST_IM : ST_IS;
            action_o.breq = (op_i == OP_STORE) ? REQ_GETM : REQ_GETS;
            action_o.miss = 1'b1;
          end
          ST_S, ST_O, ST_F: begin
            if (op_i == OP_STORE) begin
              action_o.ns   = ST_IM;
              action_o.breq = REQ_GETM;
              action_o.miss = 1'b1;
            end else begin
              action_o.to_proc = 1'b1;
            end
          end
          ST_E: begin
            action_o.to_proc = 1'b1;
            if (op_i == OP_STORE) begin
              action_o.ns     = ST_M;
              action_o.silent = 1'b1;
            end
          end
          ST_M: action_o.to_proc = 1'b1;
          default: action_o.err = ERR_PENDING;  // transient: request outstanding
        endcase
      end
      OP_GETS, OP_GETM, OP_DATA: begin
        case (state_i)
          ST_I: ;
          ST_S: begin
            if (op_i == OP_GETS) action_o.shared = 1'b1;
            else if (op_i == OP_GETM) action_o.ns = ST_I;
          end
          ST_E, ST_F: begin
            if (op_i == OP_DATA) begin
              action_o.err = ERR_INVALID;
            end else begin
              action_o.shared = 1'b1;
              action_o.on_bus = 1'b1;
              if (op_i == OP_GETM) action_o.ns = ST_I;
              else if (state_i == ST_E) action_o.ns = ST_F;
            end
          end
          ST_O, ST_M: begin
            if (op_i != OP_DATA) begin
              action_o.shared = 1'b1;
              action_o.on_bus = 1'b1;
              action_o.ns     = (op_i == OP_GETM) ? ST_I : ST_O;
            end
          end
          ST_IM: begin
            if (op_i == OP_DATA) begin
              action_o.ns      = ST_M;
              action_o.to_proc = 1'b1;
            end
          end
          default: begin  // IS
            if (op_i == OP_DATA) begin
              action_o.ns      = shared_i ? ST_S : ST_E;
              action_o.to_proc = 1'b1;
            end
          end
        endcase
      end
      default: action_o.err = ERR_INVALID;
    endcase
    // an error leaves the line as it was and drives no action
    if (action_o.err != ERR_NONE) begin
      action_o.breq    = REQ_NONE;
      action_o.to_proc = 1'b0;
      action_o.on_bus  = 1'b0;
      action_o.shared  = 1'b0;
      action_o.miss    = 1'b0;
      action_o.silent  = 1'b0;
      action_o.ns      = state_i;
    end
  end

endmodule

>>> hdl/moesif_snoop_coherence_controller.sv
// MOESIF snooping coherence controller: line state table and command port.
// After reset the block walks the state table once, one line per cycle,
// marking every line invalid; busy_o stays high until the walk is done.
// From then on busy_o is low and a command (processor load/store or snooped
// GETS/GETM/DATA) is taken in every cycle start_i is high. Each command gives
// exactly one result, shown for one cycle with done_o. The edge that takes
// the command does the registered read of the state table; the next edge
// registers the transition, the result and the write-back. A command to the
// same line as the one just before it sees that line's new state through a
// forwarding path. Results cannot be held off; take them when done_o is high.
module moesif_snoop_coherence_controller #(
  parameter int unsigned LINES         = msc_pkg::LINES_DEF,
  parameter int unsigned CACHE_ID_BITS = msc_pkg::CACHE_ID_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [msc_pkg::OP_W-1:0]       operation_i,
  input  logic [msc_pkg::LINE_IN_W-1:0]  line_index_i,
  input  logic [msc_pkg::ADDR_W-1:0]     address_i,
  input  logic [CACHE_ID_BITS-1:0]       source_id_i,
  input  logic                           shared_in_i,
  output logic                           done_o,
  output logic [1:0]                     bus_request_o,
  output logic [msc_pkg::ADDR_W-1:0]     request_address_o,
  output logic                           data_to_processor_o,
  output logic                           data_on_bus_o,
  output logic [CACHE_ID_BITS-1:0]       data_destination_o,
  output logic                           assert_shared_o,
  output logic                           miss_o,
  output logic                           silent_upgrade_o,
  output logic [1:0]                     error_code_o,
  output logic [2:0]                     new_line_state_o
);
  import msc_pkg::*;
  `include "moesif_snoop_coherence_controller_macros.svh"

  localparam int unsigned IDX_W = (LINES > 1) ? $clog2(LINES) : 1;

  logic [2:0]          mem [LINES];
  logic [2:0]          rd_q;

  logic                accept;
  logic [IDX_W-1:0]    idx;

  logic                clr_q, clr_d;
  logic [IDX_W-1:0]    clr_cnt_q, clr_cnt_d;

  logic                s1_valid_q;
  logic [OP_W-1:0]     s1_op_q;
  logic [IDX_W-1:0]    s1_idx_q;
  logic [ADDR_W-1:0]   s1_addr_q;
  logic [CACHE_ID_BITS-1:0] s1_src_q;
  logic                s1_shr_q;
  logic                fwd_hit_q;
  line_state_e         fwd_val_q;

  line_state_e         cur_state;
  action_t             act;

  logic                we;
  logic [IDX_W-1:0]    waddr;
  logic [2:0]          wdata;

  logic                done_q;
  action_t             res_q;
  logic [ADDR_W-1:0]   res_addr_q;
  logic [CACHE_ID_BITS-1:0] res_dst_q;

  assign accept = start_i && !busy_o;
  assign busy_o = clr_q;

  // line index reduced modulo LINES
  if (LINES >= (1 << LINE_IN_W)) begin : g_idx_wide
    assign idx = IDX_W'(line_index_i);
  end else begin : g_idx_mod
    logic [IDX_W-1:0] mod_tbl [1 << LINE_IN_W];
    for (genvar v = 0; v < (1 << LINE_IN_W); v++) begin : g_tbl
      assign mod_tbl[v] = IDX_W'(v % LINES);
    end
    assign idx = mod_tbl[line_index_i];
  end

  // clearing pass after reset
  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      if (clr_cnt_q == IDX_W'(LINES - 1)) clr_d = 1'b0;
      else clr_cnt_d = clr_cnt_q + 1'b1;
    end
  end

  assign cur_state = fwd_hit_q ? fwd_val_q : line_state_e'(rd_q);

  msc_xact u_xact (
    .op_i     (s1_op_q),
    .state_i  (cur_state),
    .shared_i (s1_shr_q),
    .action_o (act)
  );

  assign we    = clr_q || s1_valid_q;
  assign waddr = clr_q ? clr_cnt_q : s1_idx_q;
  assign wdata = clr_q ? ST_I : act.ns;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (accept) rd_q <= mem[idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_cnt_q  <= '0;
      s1_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      clr_q      <= clr_d;
      clr_cnt_q  <= clr_cnt_d;
      s1_valid_q <= accept;
      done_q     <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= operation_i;
      s1_idx_q  <= idx;
      s1_addr_q <= address_i;
      s1_src_q  <= source_id_i;
      s1_shr_q  <= shared_in_i;
      // write-back of the previous command lands at this same edge
      fwd_hit_q <= s1_valid_q && (s1_idx_q == idx);
      fwd_val_q <= act.ns;
    end
    if (s1_valid_q) begin
      res_q      <= act;
      res_addr_q <= (act.breq != REQ_NONE || act.to_proc || act.on_bus) ?
                    s1_addr_q : '0;
      res_dst_q  <= act.on_bus ? s1_src_q : '0;
    end
  end

  assign done_o              = done_q;
  assign bus_request_o       = res_q.breq;
  assign request_address_o   = res_addr_q;
  assign data_to_processor_o = res_q.to_proc;
  assign data_on_bus_o       = res_q.on_bus;
  assign data_destination_o  = res_dst_q;
  assign assert_shared_o     = res_q.shared;
  assign miss_o              = res_q.miss;
  assign silent_upgrade_o    = res_q.silent;
  assign error_code_o        = res_q.err;
  assign new_line_state_o    = res_q.ns;

  `MSC_ASSERT_NOW(a_no_result_while_clearing, busy_o, !done_o && !s1_valid_q)
  `MSC_ASSERT_LAT2(a_result_follows_accept, start_i && !busy_o, done_o)
  `MSC_ASSERT_NOW(a_error_is_quiet, done_o && (error_code_o != ERR_NONE), (bus_request_o == REQ_NONE) && !data_on_bus_o && !data_to_processor_o && !miss_o)
  `MSC_ASSERT_NOW(a_silent_ends_modified, done_o && silent_upgrade_o, (new_line_state_o == ST_M) && (bus_request_o == REQ_NONE))

endmodule

>>> sim/moesif_snoop_coherence_controller_tb.sv
// Self-checking testbench for the MOESIF snoop coherence controller.
module moesif_snoop_coherence_controller_tb;
  import msc_pkg::*;

  localparam int unsigned LINES       = LINES_DEF;
  localparam int unsigned ID_W        = CACHE_ID_BITS_DEF;
  localparam int unsigned RAND_CMDS   = 1900;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    bus_req_e          breq;
    logic [ADDR_W-1:0] addr;
    logic              to_proc;
    logic              on_bus;
    logic [ID_W-1:0]   dest;
    logic              shr;
    logic              miss;
    logic              silent;
    err_e              err;
    line_state_e       ns;
  } coherence_result_t;

  function automatic string show_result(coherence_result_t r);
    return $sformatf("req=%0d addr=%h proc=%0b bus=%0b dst=%0d shr=%0b miss=%0b sil=%0b err=%0d ns=%0d",
                     r.breq, r.addr, r.to_proc, r.on_bus, r.dest, r.shr, r.miss,
                     r.silent, r.err, r.ns);
  endfunction

  // Tracks line states in transfer order and holds the results still owed.
  class coherence_scoreboard;
    line_state_e       line_state [LINES];
    coherence_result_t owed_q [$];
    int unsigned       mismatches;

    function new();
      foreach (line_state[i]) line_state[i] = ST_I;
      mismatches = 0;
    endfunction

    function line_state_e state_of(int unsigned idx);
      return line_state[idx % LINES];
    endfunction

    function int unsigned outstanding();
      return owed_q.size();
    endfunction

    function void note_command(logic [OP_W-1:0] op, logic [LINE_IN_W-1:0] idx,
                               logic [ADDR_W-1:0] addr, logic [ID_W-1:0] src, logic shin);
      coherence_result_t r;
      line_state_e       cur;
      line_state_e       ns;
      int unsigned       line;
      line = idx % LINES;
      cur  = line_state[line];
      ns   = cur;
      r    = '0;
      r.breq = REQ_NONE;
      r.err  = ERR_NONE;
      case (op)
        OP_LOAD, OP_STORE: begin
          case (cur)
            ST_I: begin
              ns     = (op == OP_STORE) ? ST_IM : ST_IS;
              r.breq = (op == OP_STORE) ? REQ_GETM : REQ_GETS;
              r.miss = 1'b1;
            end
            ST_S, ST_O, ST_F: begin
              if (op == OP_STORE) begin
                ns     = ST_IM;
                r.breq = REQ_GETM;
                r.miss = 1'b1;
              end else begin
                r.to_proc = 1'b1;
              end
            end
            ST_E: begin
              r.to_proc = 1'b1;
              if (op == OP_STORE) begin
                ns       = ST_M;
                r.silent = 1'b1;
              end
            end
            ST_M: r.to_proc = 1'b1;
            default: r.err = ERR_PENDING;
          endcase
        end
        OP_GETS, OP_GETM, OP_DATA: begin
          case (cur)
            ST_I: ;
            ST_S: begin
              if (op == OP_GETS) r.shr = 1'b1;
              else if (op == OP_GETM) ns = ST_I;
            end
            ST_E, ST_F: begin
              if (op == OP_DATA) begin
                r.err = ERR_INVALID;
              end else begin
                r.shr    = 1'b1;
                r.on_bus = 1'b1;
                if (op == OP_GETM) ns = ST_I;
                else if (cur == ST_E) ns = ST_F;
              end
            end
            ST_O, ST_M: begin
              if (op != OP_DATA) begin
                r.shr    = 1'b1;
                r.on_bus = 1'b1;
                ns       = (op == OP_GETM) ? ST_I : ST_O;
              end
            end
            ST_IM: begin
              if (op == OP_DATA) begin
                ns        = ST_M;
                r.to_proc = 1'b1;
              end
            end
            default: begin
              if (op == OP_DATA) begin
                ns        = shin ? ST_S : ST_E;
                r.to_proc = 1'b1;
              end
            end
          endcase
        end
        default: r.err = ERR_INVALID;
      endcase

      if (r.err != ERR_NONE) begin
        // errors report only the code and the untouched state
        r       = '0;
        r.breq  = REQ_NONE;
        r.err   = (cur inside {ST_IM, ST_IS} && op inside {OP_LOAD, OP_STORE}) ?
                  ERR_PENDING : ERR_INVALID;
        r.ns    = cur;
      end else begin
        line_state[line] = ns;
        r.ns   = ns;
        r.addr = (r.breq != REQ_NONE || r.to_proc || r.on_bus) ? addr : '0;
        r.dest = r.on_bus ? src : '0;
      end
      owed_q.push_back(r);
    endfunction

    function void check_result(coherence_result_t got);
      coherence_result_t exp_r;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: %s", show_result(got));
        return;
      end
      exp_r = owed_q.pop_front();
      if (got.breq !== exp_r.breq || got.addr !== exp_r.addr ||
          got.to_proc !== exp_r.to_proc || got.on_bus !== exp_r.on_bus ||
          got.dest !== exp_r.dest || got.shr !== exp_r.shr ||
          got.miss !== exp_r.miss || got.silent !== exp_r.silent ||
          got.err !== exp_r.err || got.ns !== exp_r.ns) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result mismatch %0d", mismatches);
          $display("  expected %s", show_result(exp_r));
          $display("  actual   %s", show_result(got));
        end
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic [OP_W-1:0]      operation_i;
  logic [LINE_IN_W-1:0] line_index_i;
  logic [ADDR_W-1:0]    address_i;
  logic [ID_W-1:0]      source_id_i;
  logic                 shared_in_i;
  logic                 done_o;
  logic [1:0]           bus_request_o;
  logic [ADDR_W-1:0]    request_address_o;
  logic                 data_to_processor_o;
  logic                 data_on_bus_o;
  logic [ID_W-1:0]      data_destination_o;
  logic                 assert_shared_o;
  logic                 miss_o;
  logic                 silent_upgrade_o;
  logic [1:0]           error_code_o;
  logic [2:0]           new_line_state_o;

  coherence_scoreboard sb = new();
  int unsigned cycle_count = 0;

  moesif_snoop_coherence_controller dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .operation_i         (operation_i),
    .line_index_i        (line_index_i),
    .address_i           (address_i),
    .source_id_i         (source_id_i),
    .shared_in_i         (shared_in_i),
    .done_o              (done_o),
    .bus_request_o       (bus_request_o),
    .request_address_o   (request_address_o),
    .data_to_processor_o (data_to_processor_o),
    .data_on_bus_o       (data_on_bus_o),
    .data_destination_o  (data_destination_o),
    .assert_shared_o     (assert_shared_o),
    .miss_o              (miss_o),
    .silent_upgrade_o    (silent_upgrade_o),
    .error_code_o        (error_code_o),
    .new_line_state_o    (new_line_state_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Values read here are the ones held during the cycle that this edge ends.
  always @(posedge clk_i) begin
    coherence_result_t got;
    if (rst_ni) begin
      if (start_i && !busy_o)
        sb.note_command(operation_i, line_index_i, address_i, source_id_i, shared_in_i);
      if (done_o) begin
        got.breq    = bus_req_e'(bus_request_o);
        got.addr    = request_address_o;
        got.to_proc = data_to_processor_o;
        got.on_bus  = data_on_bus_o;
        got.dest    = data_destination_o;
        got.shr     = assert_shared_o;
        got.miss    = miss_o;
        got.silent  = silent_upgrade_o;
        got.err     = err_e'(error_code_o);
        got.ns      = line_state_e'(new_line_state_o);
        sb.check_result(got);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("moesif_snoop_coherence_controller: mismatch");
      $finish;
    end
  end

  // Holds the command until the block takes it.
  task automatic send_command(logic [OP_W-1:0] op, logic [LINE_IN_W-1:0] idx,
                              logic [ADDR_W-1:0] addr, logic [ID_W-1:0] src, logic shin);
    start_i      <= 1'b1;
    operation_i  <= op;
    line_index_i <= idx;
    address_i    <= addr;
    source_id_i  <= src;
    shared_in_i  <= shin;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic idle_cycle();
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [OP_W-1:0]      op;
    logic [LINE_IN_W-1:0] idx;
    line_state_e          cur;
    int unsigned          pick;
    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    operation_i  <= OP_LOAD;
    line_index_i <= '0;
    address_i    <= '0;
    source_id_i  <= '0;
    shared_in_i  <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // walk line 0 through IS, E, F, IM, M and O
    send_command(OP_GETS,  8'd0, 32'h0000_0000, 4'd15, 1'b1);
    send_command(OP_LOAD,  8'd0, 32'hFFFF_FFFF, 4'd0,  1'b0);
    send_command(OP_STORE, 8'd0, 32'h1234_5678, 4'd0,  1'b0);
    send_command(OP_DATA,  8'd0, 32'hFFFF_FFFF, 4'd3,  1'b0);
    send_command(OP_DATA,  8'd0, 32'hA5A5_A5A5, 4'd3,  1'b1);
    send_command(OP_GETS,  8'd0, 32'hFFFF_FFFF, 4'd15, 1'b0);
    send_command(OP_DATA,  8'd0, 32'h5A5A_5A5A, 4'd1,  1'b0);
    send_command(OP_LOAD,  8'd0, 32'h0000_0001, 4'd0,  1'b0);
    send_command(OP_STORE, 8'd0, 32'h8000_0000, 4'd0,  1'b1);
    send_command(OP_LOAD,  8'd0, 32'h0000_0002, 4'd0,  1'b0);
    send_command(OP_DATA,  8'd0, 32'hFFFF_FFFF, 4'd9,  1'b1);
    send_command(OP_DATA,  8'd0, 32'h0000_0003, 4'd9,  1'b0);
    send_command(OP_LOAD,  8'd0, 32'h0000_0004, 4'd0,  1'b0);
    send_command(OP_GETS,  8'd0, 32'hDEAD_BEEF, 4'd6,  1'b0);
    send_command(OP_LOAD,  8'd0, 32'h0000_0005, 4'd0,  1'b0);
    send_command(OP_GETM,  8'd0, 32'hFFFF_FFFF, 4'd15, 1'b0);
    // line 255 through S, then E with a silent upgrade
    send_command(OP_LOAD,  8'd255, 32'h0000_0010, 4'd0,  1'b0);
    send_command(OP_DATA,  8'd255, 32'h0000_0011, 4'd0,  1'b1);
    send_command(OP_GETS,  8'd255, 32'h0000_0012, 4'd5,  1'b0);
    send_command(OP_GETM,  8'd255, 32'h0000_0013, 4'd5,  1'b0);
    send_command(OP_LOAD,  8'd255, 32'h0000_0014, 4'd0,  1'b1);
    send_command(OP_DATA,  8'd255, 32'h0000_0015, 4'd0,  1'b0);
    send_command(OP_STORE, 8'd255, 32'h0000_0016, 4'd0,  1'b0);
    send_command(OP_STORE, 8'd255, 32'h0000_0017, 4'd0,  1'b0);
    send_command(OP_GETM,  8'd255, 32'h0000_0018, 4'd12, 1'b0);
    // unknown operation codes
    for (int k = OP_DATA + 1; k <= {OP_W{1'b1}}; k++)
      send_command(OP_W'(k), 8'd255, 32'hCAFE_0000, 4'd7, 1'b1);

    for (int n = 0; n < RAND_CMDS; n++) begin
      // no idling in one long stretch
      if ((n < 700 || n >= 1100) && $urandom_range(99) < 8)
        idle_cycle();
      // a few hot lines keep sequences going; the rest spans the table
      if ($urandom_range(99) < 85) idx = LINE_IN_W'($urandom_range(7) * 37);
      else idx = LINE_IN_W'($urandom_range(LINES - 1));
      cur  = sb.state_of(idx);
      pick = $urandom_range(99);
      if (cur == ST_IM || cur == ST_IS) begin
        if (pick < 75)      op = OP_DATA;
        else if (pick < 85) op = $urandom_range(1) ? OP_STORE : OP_LOAD;
        else                op = $urandom_range(1) ? OP_GETM : OP_GETS;
      end else begin
        if (pick < 3)       op = OP_W'($urandom_range(OP_DATA + 1, {OP_W{1'b1}}));
        else if (pick < 28) op = OP_LOAD;
        else if (pick < 48) op = OP_STORE;
        else if (pick < 68) op = OP_GETS;
        else if (pick < 83) op = OP_GETM;
        else                op = OP_DATA;
      end
      send_command(op, idx, ADDR_W'($urandom), ID_W'($urandom_range((1 << ID_W) - 1)),
                   1'($urandom_range(1)));
    end
    start_i <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("moesif_snoop_coherence_controller: match");
    else
      $display("moesif_snoop_coherence_controller: mismatch");
    $finish;
  end

endmodule
